// ===== sv/dxt1_block_decoder_unit_defines.svh =====
// Assertion macros shared by the DXT1 block decoder RTL.
`ifndef DXT1_BLOCK_DECODER_UNIT_DEFINES_SVH
`define DXT1_BLOCK_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DXT1_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dxt1 block decoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define DXT1_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dxt1 block decoder: next-cycle check failed");

`endif

// ===== sv/dxt1_pkg.sv =====
// Types, constants and palette helpers of the DXT1 block decoder.
`default_nettype none
package dxt1_pkg;

  localparam int CFG_W       = 15;
  localparam int CFG_INDEX_W = 1;
  localparam int BLOCK_CNT_W = 12;
  localparam int BLOCKS_W    = 14;
  localparam int COORD_W     = 14;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SIDE_RESET = 15'd4;

  // floor(x/3) == (x * 683) >> 11 for every x below 2047.
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;

  localparam logic [3:0] LAST_PIXEL = 4'd15;

  typedef struct packed {
    logic [15:0] endpoint_a;
    logic [15:0] endpoint_b;
    logic [31:0] index_word;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               inside_image;
    logic               last_of_block;
    logic               last_of_image;
  } out_word_t;

  // Clamped image geometry, shared by the front and the back.
  typedef struct packed {
    logic [CFG_W-1:0]    width;
    logic [CFG_W-1:0]    height;
    logic [BLOCKS_W-1:0] blocks_per_row;
    logic [BLOCKS_W-1:0] block_rows;
  } geom_t;

  // One classified block as it waits between front and back.
  typedef struct packed {
    logic [3:0][7:0]         red_pal;
    logic [3:0][7:0]         green_pal;
    logic [3:0][7:0]         blue_pal;
    logic [31:0]             codes;
    logic [BLOCK_CNT_W-1:0]  block_column;
    logic [BLOCK_CNT_W-1:0]  block_row;
    logic                    image_end;
  } desc_t;

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] prod;
    prod = 20'(x) * 20'(DIV3_MUL);
    return prod[DIV3_SHIFT+7:DIV3_SHIFT];
  endfunction

  function automatic logic [3:0][7:0] build_palette(input logic [7:0] c0,
                                                     input logic [7:0] c1,
                                                     input logic       four_colour);
    logic [9:0]      sum_near_a;
    logic [9:0]      sum_near_b;
    logic [9:0]      sum_mean;
    logic [3:0][7:0] pal;
    sum_near_a = {1'b0, c0, 1'b0} + {2'b00, c1};
    sum_near_b = {2'b00, c0} + {1'b0, c1, 1'b0};
    sum_mean   = {2'b00, c0} + {2'b00, c1};
    pal[0] = c0;
    pal[1] = c1;
    pal[2] = four_colour ? div3(sum_near_a) : sum_mean[8:1];
    pal[3] = four_colour ? div3(sum_near_b) : 8'd0;
    return pal;
  endfunction

endpackage
`default_nettype wire

// ===== sv/dxt1_queue.sv =====
// Two-entry block queue between the decoder's front and back.
`default_nettype none
`include "dxt1_block_decoder_unit_defines.svh"
module dxt1_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire dxt1_pkg::desc_t wr_data,
  output logic                full,
  input  wire logic           rd_en,
  output dxt1_pkg::desc_t     rd_data,
  output logic                empty
);
  import dxt1_pkg::*;

  desc_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   do_wr;
  logic                   do_rd;

  assign full    = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `DXT1_ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
  `DXT1_ASSERT_NEXT(a_write_grows, clk, rst, do_wr && !do_rd, count == $past(count) + 1'b1)
  `DXT1_ASSERT_NEXT(a_read_moves_ptr, clk, rst, do_rd, rd_ptr != $past(rd_ptr))

endmodule
`default_nettype wire

// ===== sv/dxt1_front.sv =====
// Front of the decoder: block placement counters and palette build.
`default_nettype none
module dxt1_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dxt1_pkg::geom_t   geom,
  input  wire logic              accept,
  input  wire dxt1_pkg::in_word_t in_word,
  output dxt1_pkg::desc_t        desc
);
  import dxt1_pkg::*;

  logic [BLOCK_CNT_W-1:0] block_column;
  logic [BLOCK_CNT_W-1:0] block_row;
  logic                   four_colour;
  logic                   row_end;
  logic                   rows_done;
  logic [7:0]             r0, g0, b0, r1, g1, b1;

  assign four_colour = in_word.endpoint_a > in_word.endpoint_b;

  assign r0 = {in_word.endpoint_a[15:11], 3'b000};
  assign g0 = {in_word.endpoint_a[10:5], 2'b00};
  assign b0 = {in_word.endpoint_a[4:0], 3'b000};
  assign r1 = {in_word.endpoint_b[15:11], 3'b000};
  assign g1 = {in_word.endpoint_b[10:5], 2'b00};
  assign b1 = {in_word.endpoint_b[4:0], 3'b000};

  // Greater-or-equal so counters left beyond a shrunken image still wrap.
  assign row_end   = (BLOCKS_W'(block_column) + 1'b1) >= geom.blocks_per_row;
  assign rows_done = (BLOCKS_W'(block_row) + 1'b1) >= geom.block_rows;

  always_comb begin
    desc.red_pal      = build_palette(r0, r1, four_colour);
    desc.green_pal    = build_palette(g0, g1, four_colour);
    desc.blue_pal     = build_palette(b0, b1, four_colour);
    desc.codes        = in_word.index_word;
    desc.block_column = block_column;
    desc.block_row    = block_row;
    desc.image_end    = row_end && rows_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_column <= '0;
      block_row    <= '0;
    end else if (accept) begin
      if (row_end) begin
        block_column <= '0;
        block_row    <= rows_done ? '0 : block_row + 1'b1;
      end else begin
        block_column <= block_column + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/dxt1_back.sv =====
// Back of the decoder: walks the sixteen pixels of a block into the output register.
`default_nettype none
`include "dxt1_block_decoder_unit_defines.svh"
module dxt1_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dxt1_pkg::geom_t geom,
  input  wire dxt1_pkg::desc_t head,
  input  wire logic            head_empty,
  output logic                 head_pop,
  output dxt1_pkg::out_word_t  out_word,
  output logic                 empty,
  input  wire logic            pop
);
  import dxt1_pkg::*;

  logic [3:0]         pixel;
  logic               out_valid;
  logic               advance;
  logic [1:0]         code;
  logic [COORD_W-1:0] px;
  logic [COORD_W-1:0] py;
  out_word_t          pixel_word;

  assign advance  = !head_empty && (!out_valid || pop);
  assign head_pop = advance && (pixel == LAST_PIXEL);
  assign empty    = !out_valid;

  assign code = head.codes[{pixel, 1'b0} +: 2];
  assign px   = {head.block_column, pixel[1:0]};
  assign py   = {head.block_row, pixel[3:2]};

  always_comb begin
    pixel_word.red           = head.red_pal[code];
    pixel_word.green         = head.green_pal[code];
    pixel_word.blue          = head.blue_pal[code];
    pixel_word.pixel_x       = px;
    pixel_word.pixel_y       = py;
    pixel_word.inside_image  = (CFG_W'(px) < geom.width) && (CFG_W'(py) < geom.height);
    pixel_word.last_of_block = (pixel == LAST_PIXEL);
    pixel_word.last_of_image = (pixel == LAST_PIXEL) && head.image_end;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= pixel_word;
    end
    if (rst) begin
      pixel     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      pixel     <= pixel + 1'b1;
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  `DXT1_ASSERT_NEXT(a_block_restarts, clk, rst, head_pop, pixel == 4'd0)
  `DXT1_ASSERT_IMPLIES(a_image_end_on_block_end, clk, rst,
                       out_valid && out_word.last_of_image, out_word.last_of_block)
  `DXT1_ASSERT_NEXT(a_load_shows_word, clk, rst, advance, out_valid)

endmodule
`default_nettype wire

// ===== sv/dxt1_block_decoder_unit.sv =====
// Top level of the DXT1 block decoder: configuration, front, queue and back.
//
// Usage: each input word is one compressed 4x4 DXT1 block (two RGB565
// endpoints and sixteen 2-bit codes). It is taken at a clock edge where push
// is high and full is low. The block yields sixteen output words, one per
// pixel in row order, each with its color, image coordinates and edge flags.
// The oldest waiting pixel sits on out_word while empty is low and leaves at
// an edge where pop is also high.
// A taken block is first written into the queue; when the back is free, it
// registers the block's first pixel into out_word. Throughput: one pixel per
// cycle while pop keeps up, set by the back's pixel counter and its single
// output register. The two-entry queue holds the block being walked plus one
// further block, so the front can take the next block while the back is busy
// or the receiver stalls; full rises when both entries are in use.
// A stalled receiver simply holds the current pixel; nothing is dropped.
// Reset (synchronous, active high) sets width and height to 4, places the
// next block at the image origin and empties the queue and output register.
// Width and height are written through cfg_we, cfg_index and cfg_data and
// should change only while the block is idle.
`default_nettype none
module dxt1_block_decoder_unit #(
  parameter int MAX_IMAGE_SIDE = 16384
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [dxt1_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [dxt1_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                               push,
  input  wire dxt1_pkg::in_word_t                 in_word,
  output logic                                    full,
  output logic                                    empty,
  input  wire logic                               pop,
  output dxt1_pkg::out_word_t                     out_word
);
  import dxt1_pkg::*;

  localparam int unsigned MaxSide = MAX_IMAGE_SIDE;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [CFG_W-1:0] width_clamped;
  logic [CFG_W-1:0] height_clamped;
  geom_t            geom;
  logic             accept;
  desc_t            front_desc;
  desc_t            head;
  logic             head_empty;
  logic             head_pop;

  // A side of zero counts as one; a side above the limit counts as the limit.
  function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
    if (v == '0) return CFG_W'(1);
    if (32'(v) > MaxSide) return CFG_W'(MaxSide);
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIDE_RESET;
      image_height <= SIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width_clamped  = clamp_side(image_width);
  assign height_clamped = clamp_side(image_height);

  // Blocks per row and block rows are the sides rounded up to whole blocks.
  always_comb begin
    geom.width          = width_clamped;
    geom.height         = height_clamped;
    geom.blocks_per_row = BLOCKS_W'((16'(width_clamped) + 16'd3) >> 2);
    geom.block_rows     = BLOCKS_W'((16'(height_clamped) + 16'd3) >> 2);
  end

  assign accept = push && !full;

  dxt1_front u_front (
    .clk     (clk),
    .rst     (rst),
    .geom    (geom),
    .accept  (accept),
    .in_word (in_word),
    .desc    (front_desc)
  );

  dxt1_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_desc),
    .full    (full),
    .rd_en   (head_pop),
    .rd_data (head),
    .empty   (head_empty)
  );

  dxt1_back u_back (
    .clk        (clk),
    .rst        (rst),
    .geom       (geom),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .out_word   (out_word),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
`default_nettype wire
